// File: src/tcv_pkg.sv
// Package for the Tsetlin clause vote classifier: field widths, request and
// register codes, the token struct shared by the scan stage, the vote cells
// and the top level, and the control structs of the cells. Depends on nothing.
package tcv_pkg;

   // Defaults for the top-level parameters.
   localparam int NUM_FEATURES_DEF = 64;
   localparam int CLAUSE_COUNT_DEF = 128;
   localparam int CLASS_COUNT_DEF  = 8;

   // At most eight classes are voted on, whatever the class count.
   localparam int VOTE_SLOTS = 8;

   // Field widths.
   localparam int TYPE_W        = 2;
   localparam int CLAUSE_W      = 7;
   localparam int CLASS_W       = 3;
   localparam int WEIGHT_W      = 16;
   localparam int MASK_W        = 64;
   localparam int THR_W         = 15;
   localparam int MID_W         = 8;
   localparam int CLAUSES_CFG_W = 8;
   localparam int CLASSES_CFG_W = 4;
   localparam int VOTE_W        = 16;
   localparam int FLAGS_W       = 8;

   // Port widths.
   localparam int REQ_DATA_W = 224;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // Request kinds carried in req_tuser.
   localparam logic [TYPE_W-1:0] REQ_MASKS    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_WEIGHT   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLASSIFY = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_LEVEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAUSES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASSES   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd4;

   // Token handed from cell to cell: either one clause with its fire flag,
   // or the compare marker that collects the best class and the flags.
   typedef struct packed {
      logic                valid;
      logic                is_cmp;
      logic                fire;
      logic [CLAUSE_W-1:0] addr;
      logic [VOTE_W-1:0]   best_vote;
      logic [CLASS_W-1:0]  best_idx;
      logic [FLAGS_W-1:0]  flags;
   } token_type;

   // Weight write broadcast to the cells.
   typedef struct packed {
      logic                we;
      logic [CLASS_W-1:0]  class_idx;
      logic [CLAUSE_W-1:0] addr;
      logic [WEIGHT_W-1:0] weight;
   } weight_wr_type;

   // Vote settings broadcast to the cells.
   typedef struct packed {
      logic [THR_W-1:0]         threshold;
      logic [MID_W-1:0]         mid;
      logic [CLASSES_CFG_W-1:0] ncls;
   } vote_cfg_type;

endpackage

// File: src/tsetlin_clause_vote_classifier.sv
// Top level of the Tsetlin clause vote classifier: request decode, settings,
// the clause scan stage and the chain of vote cells, and the result registers.
// Depends on tcv_pkg, tcv_clause_scan and tcv_vote_cell.
//
// A mask or weight write is one transfer and completes in the cycle it is
// taken. A classification raises rsp_tvalid once its result has passed the
// pending register into the output register. The scan reads one clause mask
// a cycle from the mask memory, n of them where n is clauses_in_use saturated
// at the stored clause count; each fire token then walks the chain of class
// cells one cell a cycle, and a compare marker following the last clause picks
// up each clamped vote on its way out. No request is taken while a
// classification runs, and a new one is taken only once the current result
// has moved to the output register, where it may still wait; while both
// result registers are full the input stalls.
module tsetlin_clause_vote_classifier #(
   parameter int NUM_FEATURES = tcv_pkg::NUM_FEATURES_DEF,
   parameter int CLAUSE_COUNT = tcv_pkg::CLAUSE_COUNT_DEF,
   parameter int CLASS_COUNT  = tcv_pkg::CLASS_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0: clause_index[6:0], class_index[9:7],
   // weight_value[25:10], positive_mask[89:26], negated_mask[153:90],
   // features[217:154], zero pad.
   input  logic [tcv_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Fields from bit 0: req_type[1:0].
   input  logic [tcv_pkg::TYPE_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0: top_class[2:0], class_flags[10:3], zero pad.
   output logic [tcv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [tcv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcv_pkg::*;

   localparam int MASK_DEPTH = (CLAUSE_COUNT < (2**CLAUSE_W)) ? CLAUSE_COUNT : (2**CLAUSE_W);
   localparam int NUM_SLOTS  = (CLASS_COUNT < VOTE_SLOTS) ? CLASS_COUNT : VOTE_SLOTS;
   localparam logic [CLAUSES_CFG_W-1:0] DEPTH_CFG = CLAUSES_CFG_W'(MASK_DEPTH);
   localparam logic [CLASSES_CFG_W-1:0] SLOTS_CFG = CLASSES_CFG_W'(NUM_SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [THR_W-1:0]         thr_ff;
   logic [MID_W-1:0]         mid_ff;
   logic [CLAUSES_CFG_W-1:0] clauses_ff;
   logic [CLASSES_CFG_W-1:0] classes_ff;
   logic                     mode_ff;
   logic                     pend_valid_ff;
   logic [CLASS_W-1:0]       pend_best_ff, rsp_best_ff;
   logic [FLAGS_W-1:0]       pend_flags_ff, rsp_flags_ff;
   logic                     rsp_valid_ff;

   logic [CLAUSE_W-1:0]      clause_index;
   logic [CLASS_W-1:0]       class_index;
   logic [WEIGHT_W-1:0]      weight_value;
   logic [MASK_W-1:0]        positive_mask, negated_mask, features;
   logic                     accept, clause_ok, start, mask_we, done, move;
   weight_wr_type            wr;
   vote_cfg_type             vcfg;
   token_type                tok_chain [NUM_SLOTS+1];

   // Unpack the request fields.
   assign clause_index  = req_tdata[6:0];
   assign class_index   = req_tdata[9:7];
   assign weight_value  = req_tdata[25:10];
   assign positive_mask = req_tdata[89:26];
   assign negated_mask  = req_tdata[153:90];
   assign features      = req_tdata[217:154];

   // Request decode; out-of-range clause writes are dropped.
   assign req_tready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign clause_ok  = ({1'b0, clause_index} < DEPTH_CFG);
   assign mask_we    = accept && (req_tuser == REQ_MASKS) && clause_ok;
   assign start      = accept && (req_tuser == REQ_CLASSIFY);

   always_comb begin
      wr.we        = accept && (req_tuser == REQ_WEIGHT) && clause_ok;
      wr.class_idx = class_index;
      wr.addr      = clause_index;
      wr.weight    = weight_value;
      vcfg.threshold = thr_ff;
      vcfg.mid       = mid_ff;
      vcfg.ncls      = (classes_ff > SLOTS_CFG) ? SLOTS_CFG : classes_ff;
   end

   // Settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THR_W'(100);
         mid_ff     <= '0;
         clauses_ff <= CLAUSES_CFG_W'(128);
         classes_ff <= CLASSES_CFG_W'(8);
         mode_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff     <= csr_wdata[THR_W-1:0];
            CSR_MID_LEVEL: mid_ff     <= csr_wdata[MID_W-1:0];
            CSR_CLAUSES:   clauses_ff <= csr_wdata[CLAUSES_CFG_W-1:0];
            CSR_CLASSES:   classes_ff <= csr_wdata[CLASSES_CFG_W-1:0];
            CSR_MODE:      mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clause scan feeds the first cell.
   tcv_clause_scan #(
      .NUM_FEATURES (NUM_FEATURES),
      .DEPTH        (MASK_DEPTH)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .mask_we        (mask_we),
      .mask_addr      (clause_index),
      .mask_pos       (positive_mask[NUM_FEATURES-1:0]),
      .mask_neg       (negated_mask[NUM_FEATURES-1:0]),
      .start          (start),
      .features       (features[NUM_FEATURES-1:0]),
      .clauses_in_use (clauses_ff),
      .tok_out        (tok_chain[0])
   );

   // Chain of class cells.
   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      tcv_vote_cell #(
         .CELL_INDEX (k),
         .DEPTH      (MASK_DEPTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (start),
         .cfg     (vcfg),
         .wr      (wr),
         .tok_in  (tok_chain[k]),
         .tok_out (tok_chain[k+1])
      );
   end

   // The compare marker leaving the last cell ends the classification.
   assign done = tok_chain[NUM_SLOTS].valid && tok_chain[NUM_SLOTS].is_cmp;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_BUSY;
         ST_BUSY: if (done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Result goes to a pending register, then to the output register.
   assign move = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done) begin
            pend_valid_ff <= 1'b1;
         end else if (move) begin
            pend_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, with the unused field zeroed by mode.
   always_ff @(posedge clock) begin
      if (done) begin
         pend_best_ff  <= mode_ff ? '0 : tok_chain[NUM_SLOTS].best_idx;
         pend_flags_ff <= mode_ff ? tok_chain[NUM_SLOTS].flags : '0;
      end
      if (move) begin
         rsp_best_ff  <= pend_best_ff;
         rsp_flags_ff <= pend_flags_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-FLAGS_W-CLASS_W){1'b0}}, rsp_flags_ff, rsp_best_ff};

   // The compare marker only leaves the chain during a classification.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff == ST_BUSY))
      else $error("compare marker left the chain outside a classification");

   // No token enters the chain while the block is idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !tok_chain[0].valid)
      else $error("token entered the cell chain while idle");

   // A pending result only appears at the end of a classification.
   a_pend_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_valid_ff) |-> ($past(state_ff) == ST_BUSY))
      else $error("pending result set without a classification");

endmodule

// File: src/tcv_clause_scan.sv
// Clause scan stage: holds the include masks of every clause, walks the
// clauses in order and emits one fire token per clause, then the compare
// marker. Depends on tcv_pkg.
module tcv_clause_scan #(
   parameter int NUM_FEATURES = tcv_pkg::NUM_FEATURES_DEF,
   parameter int DEPTH        = tcv_pkg::CLAUSE_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               mask_we,
   input  logic [tcv_pkg::CLAUSE_W-1:0]       mask_addr,
   input  logic [NUM_FEATURES-1:0]            mask_pos,
   input  logic [NUM_FEATURES-1:0]            mask_neg,
   input  logic                               start,
   input  logic [NUM_FEATURES-1:0]            features,
   input  logic [tcv_pkg::CLAUSES_CFG_W-1:0]  clauses_in_use,
   output tcv_pkg::token_type                 tok_out
);
   import tcv_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CLAUSES_CFG_W-1:0] DEPTH_CFG = CLAUSES_CFG_W'(DEPTH);

   logic [2*NUM_FEATURES-1:0] mask_mem [DEPTH];
   logic [2*NUM_FEATURES-1:0] rd_ff;
   logic [DEPTH-1:0]          written_ff;
   logic [NUM_FEATURES-1:0]   feat_ff;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          limit_ff, limit_in;
   logic                      run_ff, run_in;
   logic                      a_valid_ff, a_valid_in;
   logic                      a_cmp_ff, a_cmp_in;
   logic                      a_ok_ff;
   logic [CLAUSE_W-1:0]       a_addr_ff;
   token_type                 tok_ff, tok_in;
   logic [CLAUSES_CFG_W-1:0]  limit_cfg;
   logic [NUM_FEATURES-1:0]   pos, neg;

   // Clause count of one pass, saturated at the stored clause count.
   assign limit_cfg = (clauses_in_use > DEPTH_CFG) ? DEPTH_CFG : clauses_in_use;

   // Scan counter: one clause read a cycle, then the compare marker.
   always_comb begin
      run_in     = run_ff;
      cnt_in     = cnt_ff;
      limit_in   = limit_ff;
      a_valid_in = 1'b0;
      a_cmp_in   = 1'b0;
      if (start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         limit_in = CNT_W'(limit_cfg);
      end else if (run_ff) begin
         a_valid_in = 1'b1;
         if (cnt_ff == limit_ff) begin
            a_cmp_in = 1'b1;
            run_in   = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         cnt_ff     <= '0;
         limit_ff   <= '0;
         a_valid_ff <= 1'b0;
         a_cmp_ff   <= 1'b0;
      end else begin
         run_ff     <= run_in;
         cnt_ff     <= cnt_in;
         limit_ff   <= limit_in;
         a_valid_ff <= a_valid_in;
         a_cmp_ff   <= a_cmp_in;
      end
   end

   // Mask memory, negated mask in the upper half, registered read.
   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_mem[mask_addr[AW-1:0]] <= {mask_neg, mask_pos};
      end
      rd_ff <= mask_mem[cnt_ff[AW-1:0]];
   end

   // Written flags: a clause never written can never fire.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mask_we) begin
         written_ff[mask_addr[AW-1:0]] <= 1'b1;
      end
   end

   // Payload registers of the read stage and the latched features.
   always_ff @(posedge clock) begin
      a_ok_ff   <= written_ff[cnt_ff[AW-1:0]];
      a_addr_ff <= CLAUSE_W'(cnt_ff);
      if (start) begin
         feat_ff <= features;
      end
   end

   // Fire test: at least one literal included, all included literals true.
   assign pos = rd_ff[NUM_FEATURES-1:0];
   assign neg = rd_ff[2*NUM_FEATURES-1:NUM_FEATURES];

   always_comb begin
      tok_in           = '0;
      tok_in.valid     = a_valid_ff;
      tok_in.is_cmp    = a_cmp_ff;
      tok_in.addr      = a_addr_ff;
      tok_in.fire      = a_ok_ff && (|rd_ff) && ((pos & ~feat_ff) == '0)
                         && ((neg & feat_ff) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: src/tcv_vote_cell.sv
// Vote cell: one class slot with its own weight memory and vote sum. Clause
// tokens that fire accumulate weights; the compare marker collects the clamped vote.
// Depends on tcv_pkg.
module tcv_vote_cell #(
   parameter int CELL_INDEX = 0,
   parameter int DEPTH      = tcv_pkg::CLAUSE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  tcv_pkg::vote_cfg_type cfg,
   input  tcv_pkg::weight_wr_type wr,
   input  tcv_pkg::token_type    tok_in,
   output tcv_pkg::token_type    tok_out
);
   import tcv_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ACC_W = WEIGHT_W + AW + 1;
   localparam logic [CLASS_W-1:0]       MY_CLASS = CLASS_W'(CELL_INDEX);
   localparam logic [CLASSES_CFG_W-1:0] MY_SLOT  = CLASSES_CFG_W'(CELL_INDEX);
   localparam bit FIRST = (CELL_INDEX == 0);

   logic [WEIGHT_W-1:0]     wmem [DEPTH];
   logic [WEIGHT_W-1:0]     w_rd_ff;
   token_type               tok_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] thr_s, clamped;
   logic signed [VOTE_W-1:0] vote, best_s, mid_s;
   logic                    active, take;

   // Weight memory of this class, read at the address of the passing token.
   always_ff @(posedge clock) begin
      if (wr.we && (wr.class_idx == MY_CLASS)) begin
         wmem[wr.addr[AW-1:0]] <= wr.weight;
      end
      w_rd_ff <= wmem[tok_in.addr[AW-1:0]];
   end

   // Vote sum: cleared at the start of a classification.
   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (tok_ff.valid && !tok_ff.is_cmp && tok_ff.fire) begin
         acc_in = acc_ff + {{(ACC_W-WEIGHT_W){w_rd_ff[WEIGHT_W-1]}}, w_rd_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         acc_ff <= '0;
      end else begin
         tok_ff <= tok_in;
         acc_ff <= acc_in;
      end
   end

   // Clamp to the threshold and fold into the running compare.
   always_comb begin
      thr_s = $signed({{(ACC_W-THR_W){1'b0}}, cfg.threshold});
      if (acc_ff > thr_s) begin
         clamped = thr_s;
      end else if (acc_ff < -thr_s) begin
         clamped = -thr_s;
      end else begin
         clamped = acc_ff;
      end
      vote   = clamped[VOTE_W-1:0];
      best_s = $signed(tok_ff.best_vote);
      mid_s  = $signed({{(VOTE_W-MID_W){cfg.mid[MID_W-1]}}, cfg.mid});
      active = (MY_SLOT < cfg.ncls);
      take   = active && (FIRST || (vote > best_s));

      tok_out = tok_ff;
      if (tok_ff.is_cmp) begin
         if (take) begin
            tok_out.best_vote = vote;
            tok_out.best_idx  = MY_CLASS;
         end
         if (active && (vote > mid_s)) begin
            tok_out.flags[CELL_INDEX] = 1'b1;
         end
      end
   end

endmodule
